>>> rtl/dns_name_label_encoder_top_macros.svh
// Assertion macros for the DNS name label encoder checker.
// Used by dnle_checker.sv only; no other dependencies.
`ifndef DNS_NAME_LABEL_ENCODER_TOP_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_MACROS_SVH

// a |-> b, disabled in reset
`define DNLE_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("dnle checker: implication failed");

// a |=> b, disabled in reset
`define DNLE_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("dnle checker: next-cycle check failed");

// a |=> b, checked through reset as well
`define DNLE_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("dnle checker: check across reset failed");

`endif

>>> rtl/dnle_pkg.sv
// Package for the DNS name label encoder: sizes, codes, queue command type.
// No dependencies; used by the front, queue, back and top RTL files.
`timescale 1ns / 1ps

package dnle_pkg;

   localparam int LABEL_MAX   = 62;
   localparam int CNT_W       = $clog2(LABEL_MAX + 1);
   localparam int ADDR_W      = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] DOT_CHAR = 8'd46;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // store: data goes to buffer entry count
   // flush: emit count label bytes (if any) with trunc flag, then zero byte if term
   typedef struct packed {
      logic             kind;
      logic             term;
      logic             trunc;
      logic [CNT_W-1:0] count;
      logic [7:0]       data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/dnle_req_if.sv
// Input channel of the DNS name label encoder: one host name character.
// Depends on nothing.
`timescale 1ns / 1ps

interface dnle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_name;

   modport source (output valid, output in_char, output end_of_name, input ready);
   modport sink   (input valid, input in_char, input end_of_name, output ready);
endinterface

>>> rtl/dnle_rsp_if.sv
// Result channel of the DNS name label encoder: one wire-format byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface dnle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       overflow;

   modport source (output valid, output out_byte, output last, output overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input overflow,
                   output ready);
endinterface

>>> rtl/dnle_queue.sv
// Short command queue between the front and back parts of the encoder.
// Depends on dnle_pkg.
`timescale 1ns / 1ps

module dnle_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dnle_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output dnle_pkg::cmd_type          head_cmd,
   output dnle_pkg::queue_status_type status
);

   dnle_pkg::cmd_type               entries_ff [dnle_pkg::QUEUE_DEPTH];
   logic [dnle_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dnle_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dnle_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.full  = (count_ff == dnle_pkg::QCNT_W'(dnle_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dnle_pkg::QPTR_W'(dnle_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + dnle_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dnle_pkg::QPTR_W'(dnle_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + dnle_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + dnle_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - dnle_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/dnle_front.sv
// Front part: accepts characters, tracks label length and truncation,
// and emits store or flush commands from the transactions. Depends on dnle_pkg.
`timescale 1ns / 1ps

module dnle_front (
   input  logic                       clock,
   input  logic                       reset,
   dnle_req_if.sink                   req_ch,
   input  dnle_pkg::queue_status_type q_status,
   output logic                       push,
   output dnle_pkg::cmd_type          push_cmd
);

   logic [dnle_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       trunc_ff, trunc_in;
   logic                       accept;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      count_in       = count_ff;
      trunc_in       = trunc_ff;
      push           = 1'b0;
      push_cmd.kind  = dnle_pkg::CMD_FLUSH;
      push_cmd.term  = 1'b0;
      push_cmd.trunc = trunc_ff;
      push_cmd.count = count_ff;
      push_cmd.data  = req_ch.in_char;
      if (accept) begin
         if (req_ch.end_of_name) begin
            push          = 1'b1;
            push_cmd.term = 1'b1;
            count_in      = '0;
            trunc_in      = 1'b0;
         end else if (req_ch.in_char == dnle_pkg::DOT_CHAR) begin
            // empty label: nothing to flush
            push     = (count_ff != '0);
            count_in = '0;
            trunc_in = 1'b0;
         end else if (count_ff < dnle_pkg::CNT_W'(dnle_pkg::LABEL_MAX)) begin
            push          = 1'b1;
            push_cmd.kind = dnle_pkg::CMD_STORE;
            count_in      = count_ff + dnle_pkg::CNT_W'(1);
         end else begin
            trunc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         trunc_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         trunc_ff <= trunc_in;
      end
   end

endmodule

>>> rtl/dnle_back.sv
// Back part: holds the label buffer, writes stored characters and plays out
// flushed labels and terminators into the output register. Depends on dnle_pkg.
`timescale 1ns / 1ps

module dnle_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dnle_pkg::cmd_type          head_cmd,
   input  dnle_pkg::queue_status_type q_status,
   output logic                       pop,
   dnle_rsp_if.source                 rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_CHAR = 2'd2;
   localparam logic [1:0] ST_TERM = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [dnle_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [dnle_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                        trunc_ff, trunc_in;
   logic                        term_ff, term_in;

   logic [7:0]                  label_mem [dnle_pkg::LABEL_MAX];
   logic [7:0]                  rd_data_ff;
   logic                        mem_we;

   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_ovf_ff, out_ovf_in;
   logic                        load_ok, load;

   assign load_ok = !out_valid_ff || rsp_ch.ready;
   assign pop     = (state_ff == ST_IDLE) && !q_status.empty;
   assign mem_we  = pop && (head_cmd.kind == dnle_pkg::CMD_STORE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      trunc_in    = trunc_ff;
      term_in     = term_ff;
      load        = 1'b0;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (pop && head_cmd.kind == dnle_pkg::CMD_FLUSH) begin
               cnt_in   = head_cmd.count;
               trunc_in = head_cmd.trunc;
               term_in  = head_cmd.term;
               state_in = (head_cmd.count != '0) ? ST_LEN : ST_TERM;
            end
         end
         ST_LEN: begin
            if (load_ok) begin
               load        = 1'b1;
               out_byte_in = 8'(cnt_ff);
               out_last_in = 1'b0;
               out_ovf_in  = trunc_ff;
               state_in    = ST_CHAR;
            end
         end
         ST_CHAR: begin
            // rd_data_ff holds entry idx_ff; address only moves on a load
            if (load_ok) begin
               load        = 1'b1;
               out_byte_in = rd_data_ff;
               out_last_in = 1'b0;
               out_ovf_in  = trunc_ff;
               if (dnle_pkg::CNT_W'(idx_ff + dnle_pkg::CNT_W'(1)) == cnt_ff) begin
                  state_in = term_ff ? ST_TERM : ST_IDLE;
               end else begin
                  idx_in = idx_ff + dnle_pkg::CNT_W'(1);
               end
            end
         end
         ST_TERM: begin
            if (load_ok) begin
               load        = 1'b1;
               out_byte_in = 8'd0;
               out_last_in = 1'b1;
               out_ovf_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      trunc_ff    <= trunc_in;
      term_ff     <= term_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         label_mem[head_cmd.count[dnle_pkg::ADDR_W-1:0]] <= head_cmd.data;
      end
      rd_data_ff <= label_mem[idx_in[dnle_pkg::ADDR_W-1:0]];
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.last     = out_last_ff;
   assign rsp_ch.overflow = out_ovf_ff;

endmodule

>>> rtl/dns_name_label_encoder_top.sv
// Channel   Dir  Payload                          Handshake
// req_ch    in   in_char[7:0], end_of_name        valid/ready
// rsp_ch    out  out_byte[7:0], last, overflow    valid/ready
//
// A character is taken whenever req_ch.ready is high; the front stalls only when the command
// queue (two entries) is full. A flush of an n-character label pops the command,
// then outputs the length byte and the n characters, plus the zero byte at end of name.
// Reset is synchronous and clears the front counters, queue, back state and output
// valid, not the back counters or the label buffer memory. Output backpressure holds the
// output register and the playout, and fills the queue before req stalls.
// Depends on dnle_pkg, dnle_req_if, dnle_rsp_if, dnle_front, dnle_queue, dnle_back.
`timescale 1ns / 1ps

module dns_name_label_encoder_top (
   input  logic       clock,
   input  logic       reset,
   dnle_req_if.sink   req_ch,
   dnle_rsp_if.source rsp_ch
);

   dnle_pkg::queue_status_type q_status;
   dnle_pkg::cmd_type          push_cmd;
   dnle_pkg::cmd_type          head_cmd;
   logic                       push;
   logic                       pop;

   dnle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   dnle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   dnle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> rtl/dnle_checker.sv
// Port-level checker for the DNS name label encoder, bound to the top level.
// Depends on dns_name_label_encoder_top_macros.svh.
`timescale 1ns / 1ps
`include "dns_name_label_encoder_top_macros.svh"

module dnle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_overflow
);

   logic       rsp_stall;
   logic [9:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_byte, rsp_last, rsp_overflow};

   `DNLE_ASSERT_NEXT_ALWAYS(a_rsp_idle_after_reset, clock, reset, !rsp_valid)
   `DNLE_ASSERT_IMPLY(a_term_is_zero, clock, reset, rsp_valid && rsp_last, rsp_out_byte == 8'd0)
   `DNLE_ASSERT_IMPLY(a_term_no_ovf, clock, reset, rsp_valid && rsp_last, !rsp_overflow)
   `DNLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind dns_name_label_encoder_top dnle_checker u_dnle_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_last     (rsp_ch.last),
   .rsp_overflow (rsp_ch.overflow)
);

>>> bench/tb_top.sv
// Self-checking bench for dns_name_label_encoder_top: random host names in, wire bytes checked.
// Depends on dnle_pkg, dnle_req_if, dnle_rsp_if and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS = 250;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [7:0] ch;
      logic       eon;
      bit         hold;   // wait for all pending wire bytes before sending
   } name_item_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       overflow;
   } wire_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dnle_req_if req_ch ();
   dnle_rsp_if rsp_ch ();

   dns_name_label_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   name_item_type char_q[$];
   wire_byte_type wire_q[$];
   int            n_queued  = 0;
   bit            hold_next = 1'b0;
   int            n_errors  = 0;

   // encoder image: current label characters, count and truncation flag
   logic [7:0]                 lbl_buf [dnle_pkg::LABEL_MAX];
   logic [dnle_pkg::CNT_W-1:0] lbl_len = '0;
   logic                       lbl_cut = 1'b0;

   task automatic flush_label();
      if (lbl_len != 0) begin
         wire_q.push_back('{8'(lbl_len), 1'b0, lbl_cut});
         for (int i = 0; i < lbl_len; i++)
            wire_q.push_back('{lbl_buf[i], 1'b0, lbl_cut});
      end
      lbl_len = '0;
      lbl_cut = 1'b0;
   endtask

   task automatic encode_char(input logic [7:0] ch, input logic eon);
      if (eon) begin
         flush_label();
         wire_q.push_back('{8'h00, 1'b1, 1'b0});
      end else if (ch == dnle_pkg::DOT_CHAR) begin
         flush_label();
      end else if (lbl_len < dnle_pkg::LABEL_MAX) begin
         lbl_buf[lbl_len] = ch;
         lbl_len = lbl_len + 1'b1;
      end else begin
         lbl_cut = 1'b1;
      end
   endtask

   // stimulus construction
   function automatic logic [7:0] label_char();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == dnle_pkg::DOT_CHAR);
      return v;
   endfunction

   task automatic add_item(input logic [7:0] ch, input logic eon);
      char_q.push_back('{ch, eon, hold_next});
      hold_next = 1'b0;
      n_queued++;
   endtask

   task automatic add_name(input int long_len);
      int n_lbl;
      int len;
      n_lbl = $urandom_range(0, 4);
      if (long_len > 0 && n_lbl == 0)
         n_lbl = 1;
      if ($urandom_range(0, 5) == 0)
         add_item(dnle_pkg::DOT_CHAR, 1'b0);
      for (int k = 0; k < n_lbl; k++) begin
         if (k > 0) begin
            add_item(dnle_pkg::DOT_CHAR, 1'b0);
            if ($urandom_range(0, 5) == 0)
               add_item(dnle_pkg::DOT_CHAR, 1'b0);
         end
         len = (k == 0 && long_len > 0) ? long_len : $urandom_range(1, 9);
         repeat (len) add_item(label_char(), 1'b0);
         // stray byte, may be a dot
         if ($urandom_range(0, 9) == 0)
            add_item(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 5) == 0)
         add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 15) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // sender
   bit            req_hit  = 1'b0;
   bit            req_busy = 1'b0;
   bit            req_calm = 1'b0;
   int            req_gap  = 0;
   name_item_type cur_item;

   always @(posedge clock) begin
      req_hit <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         encode_char(req_ch.in_char, req_ch.end_of_name);
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_hit) begin
            req_busy = 1'b0;
            req_gap  = draw_gap(req_calm);
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (char_q.size() > 0 && !(char_q[0].hold && wire_q.size() > 0)) begin
               cur_item = char_q.pop_front();
               req_ch.in_char     <= cur_item.ch;
               req_ch.end_of_name <= cur_item.eon;
               req_busy = 1'b1;
            end
         end
         req_ch.valid <= req_busy;
      end
   end

   // receiver and checker
   bit            rsp_calm  = 1'b0;
   int            rsp_stall = 0;
   wire_byte_type want;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            rsp_stall = draw_gap(rsp_calm);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (wire_q.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("%0t: unexpected byte %02h last %b ovf %b", $realtime,
                        rsp_ch.out_byte, rsp_ch.last, rsp_ch.overflow);
         end else begin
            want = wire_q.pop_front();
            if (rsp_ch.out_byte !== want.value || rsp_ch.last !== want.last ||
                rsp_ch.overflow !== want.overflow) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("%0t: expected byte %02h last %b ovf %b, got %02h %b %b",
                           $realtime, want.value, want.last, want.overflow,
                           rsp_ch.out_byte, rsp_ch.last, rsp_ch.overflow);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL dns_name_label_encoder_top");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int directed_n;
      int name_idx;
      req_ch.valid       = 1'b0;
      req_ch.in_char     = 8'h00;
      req_ch.end_of_name = 1'b0;
      rsp_ch.ready       = 1'b0;

      // empty name, leading dot, end of name carrying a dot
      add_item(8'hFF, 1'b1);
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(dnle_pkg::DOT_CHAR, 1'b1);
      // zero and all-ones characters, doubled and trailing dots
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(8'h41, 1'b0);
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(8'h80, 1'b0);
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(8'h00, 1'b1);
      // dots only
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(dnle_pkg::DOT_CHAR, 1'b0);
      add_item(8'h55, 1'b1);
      // sender drains the output before this name
      hold_next = 1'b1;
      add_item(8'h7E, 1'b0);
      add_item(8'h01, 1'b0);
      add_item(8'hAA, 1'b1);
      // single-character label
      add_item(8'h2F, 1'b0);
      add_item(8'h2D, 1'b1);
      directed_n = n_queued;

      name_idx = 0;
      while (n_queued < directed_n + RANDOM_ITEMS) begin
         if ($urandom_range(0, 11) == 0)
            hold_next = 1'b1;
         if (name_idx == 0)
            add_name(dnle_pkg::LABEL_MAX + $urandom_range(1, 4));   // truncated label
         else if (name_idx == 1)
            add_name(dnle_pkg::LABEL_MAX);                          // exactly at the cap
         else if ($urandom_range(0, 29) == 0)
            add_name($urandom_range(dnle_pkg::LABEL_MAX - 2, dnle_pkg::LABEL_MAX + 3));
         else if ($urandom_range(0, 9) == 0) begin
            // raw garbage name
            repeat ($urandom_range(1, 12)) add_item(8'($urandom_range(0, 255)), 1'b0);
            add_item(8'($urandom_range(0, 255)), 1'b1);
         end else
            add_name(0);
         name_idx++;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_q.size() > 0 || req_busy)
         @(posedge clock);
      while (wire_q.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (n_errors == 0 && wire_q.size() == 0)
         $display("PASS dns_name_label_encoder_top");
      else
         $display("FAIL dns_name_label_encoder_top");
      $finish;
   end

endmodule
